// File: src/lbtfm_pkg.sv
// ----------------------------------------------------------------------------
// lbtfm_pkg
// Shared types and constants for the light barrier trigger and fault monitor.
// ----------------------------------------------------------------------------
package lbtfm_pkg;

    localparam int unsigned NUM_SENSORS_DEF = 5;
    localparam int unsigned LEVELS_W        = 5;
    localparam int unsigned CFG_W           = 16;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned APB_DATA_W      = 32;
    localparam int unsigned APB_ADDR_W      = 4;

    localparam logic [CFG_W-1:0] COOLDOWN_RST    = 16'd2000;
    localparam logic [CFG_W-1:0] STARTUP_RST     = 16'd4000;
    localparam logic [CFG_W-1:0] FAULT_DELAY_RST = 16'd3000;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_EDGE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_COOLDOWN    = 2'd0,
        REG_STARTUP     = 2'd1,
        REG_FAULT_DELAY = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] cooldown_ms;
        logic [CFG_W-1:0] startup_blank_ms;
        logic [CFG_W-1:0] fault_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic start_signal;
        logic beep_trigger;
        logic fault_change;
        logic fault_active;
    } t_result;

endpackage

// File: src/lbtfm_regs.sv
// ----------------------------------------------------------------------------
// lbtfm_regs
// APB configuration registers: cooldown, startup blank and fault delay.
// ----------------------------------------------------------------------------
module lbtfm_regs
    import lbtfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_COOLDOWN:    n_cfg.cooldown_ms      = pwdata[CFG_W-1:0];
                REG_STARTUP:     n_cfg.startup_blank_ms = pwdata[CFG_W-1:0];
                REG_FAULT_DELAY: n_cfg.fault_delay_ms   = pwdata[CFG_W-1:0];
                default:         n_cfg                  = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_COOLDOWN:    prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_cfg.cooldown_ms};
            REG_STARTUP:     prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_cfg.startup_blank_ms};
            REG_FAULT_DELAY: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_cfg.fault_delay_ms};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cooldown_ms      <= COOLDOWN_RST;
            r_cfg.startup_blank_ms <= STARTUP_RST;
            r_cfg.fault_delay_ms   <= FAULT_DELAY_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: src/lbtfm_core.sv
// ----------------------------------------------------------------------------
// lbtfm_core
// Millisecond clock, trigger cooldown and warning/fault state, one item per
// advance.
// ----------------------------------------------------------------------------
module lbtfm_core
    import lbtfm_pkg::*;
#(
    parameter int unsigned NUM_SENSORS = NUM_SENSORS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  t_cmd                i_cmd,
    input  logic [LEVELS_W-1:0] i_levels,
    input  t_cfg                i_cfg,
    output t_result             o_result
);

    localparam int unsigned LP_USED = (NUM_SENSORS < LEVELS_W) ? NUM_SENSORS : LEVELS_W;

    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_last, n_last;
    logic [TIME_W-1:0] r_ws, n_ws;
    logic              r_warn, n_warn;
    logic              r_fault, n_fault;

    logic              w_trig;
    logic              w_chk;
    logic              w_bad;
    logic              w_expired;
    logic [TIME_W-1:0] w_age;
    logic [TIME_W:0]   w_limit;

    always_comb begin
        n_now = r_now;
        if (i_cmd == CMD_TICK && r_now != {TIME_W{1'b1}}) begin
            n_now = r_now + 1'b1;
        end
    end

    assign w_limit   = {1'b0, r_last} + {{(TIME_W+1-CFG_W){1'b0}}, i_cfg.cooldown_ms};
    assign w_trig    = (i_cmd == CMD_EDGE) && ({1'b0, r_now} > w_limit) && !r_fault;
    assign w_chk     = n_now > {{(TIME_W-CFG_W){1'b0}}, i_cfg.startup_blank_ms};
    assign w_bad     = |i_levels[LP_USED-1:0];
    assign w_age     = n_now - r_ws;
    assign w_expired = r_warn && (w_age > {{(TIME_W-CFG_W){1'b0}}, i_cfg.fault_delay_ms});

    always_comb begin
        n_last  = w_trig ? r_now : r_last;
        n_warn  = r_warn;
        n_ws    = r_ws;
        n_fault = r_fault;
        if (w_chk) begin
            if (w_bad) begin
                n_warn  = 1'b1;
                n_ws    = r_warn ? r_ws : n_now;
                n_fault = r_fault || w_expired;
            end else begin
                n_warn  = 1'b0;
                n_fault = 1'b0;
            end
        end
    end

    always_comb begin
        o_result.start_signal = w_trig;
        o_result.beep_trigger = w_trig;
        o_result.fault_change = n_fault ^ r_fault;
        o_result.fault_active = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_last  <= '0;
            r_ws    <= '0;
            r_warn  <= 1'b0;
            r_fault <= 1'b0;
        end else if (i_adv) begin
            r_now   <= n_now;
            r_last  <= n_last;
            r_ws    <= n_ws;
            r_warn  <= n_warn;
            r_fault <= n_fault;
        end
    end

endmodule

// File: src/light_barrier_trigger_fault_monitor.sv
// ----------------------------------------------------------------------------
// light_barrier_trigger_fault_monitor
// Light barrier trigger with cooldown and sensor fault monitor.
// ----------------------------------------------------------------------------
// One result per input transfer. An item is registered on entry, evaluated once
// the output register can take its result, against the clock, trigger and fault
// state, and its result held in an output register. A new item is taken every
// cycle while the output side keeps up. Throughput is bounded only by the single
// result register; when it is held the input register absorbs one more item
// before ready drops.
module light_barrier_trigger_fault_monitor
    import lbtfm_pkg::*;
#(
    parameter int unsigned NUM_SENSORS = NUM_SENSORS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [LEVELS_W-1:0]   i_sensor_levels,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_start_signal,
    output logic                  o_beep_trigger,
    output logic                  o_fault_change,
    output logic                  o_fault_active,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg                w_cfg;
    t_result             w_result;
    logic                w_adv;

    logic                r_in_valid;
    t_cmd                r_cmd;
    logic [LEVELS_W-1:0] r_levels;
    logic                r_out_valid;
    t_result             r_result;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    lbtfm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lbtfm_core #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_cmd    (r_cmd),
        .i_levels (r_levels),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_levels <= i_sensor_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_start_signal = r_result.start_signal;
    assign o_beep_trigger = r_result.beep_trigger;
    assign o_fault_change = r_result.fault_change;
    assign o_fault_active = r_result.fault_active;

endmodule
